// ===== src/vpa_pkg.sv =====
package vpa_pkg;

    typedef enum logic [1:0] {
        ACT_FIRST_FIT = 2'd0,
        ACT_BEST_FIT  = 2'd1,
        ACT_WORST_FIT = 2'd2,
        ACT_FREE      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_TABLE_FULL = 2'd2
    } status_t;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_LENGTH = 1'd1;

    // controller -> datapath
    typedef struct packed {
        logic init_write;
        logic load_item;
        logic set_full;
        logic set_no_fit;
        logic scan_rd;
        logic scan_ev;
        logic pass_start;
        logic pass_rd;
        logic pass_ev;
        logic pass_ev2;
        logic pass_end;
        logic flush;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cfg_hit;
        logic is_free;
        logic table_full;
        logic table_empty;
        logic scan_done;
        logic found;
        logic at_end;
        logic ins_before;
        logic out_busy;
    } sts_t;

endpackage

// ===== src/vpa_ctrl.sv =====
module vpa_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  vpa_pkg::sts_t  sts,
    output vpa_pkg::cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_INIT     = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_DISPATCH = 11'b00000000100,
        S_SC_RD    = 11'b00000001000,
        S_SC_EV    = 11'b00000010000,
        S_SC_CHK   = 11'b00000100000,
        S_PS_RD    = 11'b00001000000,
        S_PS_EV    = 11'b00010000000,
        S_PS_EV2   = 11'b00100000000,
        S_PS_END   = 11'b01000000000,
        S_FLUSH    = 11'b10000000000
    } state_t;

    typedef enum logic [0:0] {
        D_WAIT = 1'b0,
        D_DONE = 1'b1
    } done_t;

    state_t state_reg, state_next;
    done_t  done_reg, done_next;

    assign in_ready = (state_reg == S_IDLE) && (done_reg == D_WAIT);

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        cmd        = '0;
        if (done_reg == D_DONE)
        begin
            // hold until the output register is free
            if (!sts.out_busy)
            begin
                cmd.finish = 1'b1;
                done_next  = D_WAIT;
            end
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    cmd.init_write = 1'b1;
                    state_next = sts.cfg_hit ? S_INIT : S_IDLE;
                end
                S_IDLE:
                begin
                    if (sts.cfg_hit)
                    begin
                        state_next = S_INIT;
                    end
                    else if (in_valid)
                    begin
                        cmd.load_item = 1'b1;
                        state_next = S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    if (sts.is_free)
                    begin
                        if (sts.table_full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next = S_IDLE;
                            done_next  = D_DONE;
                        end
                        else
                        begin
                            cmd.pass_start = 1'b1;
                            state_next = S_PS_RD;
                        end
                    end
                    else if (sts.table_empty)
                    begin
                        cmd.set_no_fit = 1'b1;
                        state_next = S_IDLE;
                        done_next  = D_DONE;
                    end
                    else
                    begin
                        state_next = S_SC_RD;
                    end
                end
                S_SC_RD:
                begin
                    cmd.scan_rd = 1'b1;
                    state_next = S_SC_EV;
                end
                S_SC_EV:
                begin
                    cmd.scan_ev = 1'b1;
                    state_next = sts.scan_done ? S_SC_CHK : S_SC_RD;
                end
                S_SC_CHK:
                begin
                    if (sts.found)
                    begin
                        cmd.pass_start = 1'b1;
                        state_next = S_PS_RD;
                    end
                    else
                    begin
                        cmd.set_no_fit = 1'b1;
                        state_next = S_IDLE;
                        done_next  = D_DONE;
                    end
                end
                S_PS_RD:
                begin
                    if (sts.at_end)
                    begin
                        state_next = S_PS_END;
                    end
                    else
                    begin
                        cmd.pass_rd = 1'b1;
                        state_next = S_PS_EV;
                    end
                end
                S_PS_EV:
                begin
                    cmd.pass_ev = 1'b1;
                    state_next = sts.ins_before ? S_PS_EV2 : S_PS_RD;
                end
                S_PS_EV2:
                begin
                    cmd.pass_ev2 = 1'b1;
                    state_next = S_PS_RD;
                end
                S_PS_END:
                begin
                    cmd.pass_end = 1'b1;
                    state_next = S_FLUSH;
                end
                S_FLUSH:
                begin
                    cmd.flush = 1'b1;
                    state_next = S_IDLE;
                    done_next  = D_DONE;
                end
                default:
                begin
                    state_next = S_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= D_WAIT;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== src/vpa_dpath.sv =====
module vpa_dpath
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int ADDR_BITS    = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [1:0]                     action,
    input  logic [ADDR_BITS-1:0]           address,
    input  logic [ADDR_BITS-1:0]           request_size,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [ADDR_BITS-1:0]           granted_address,
    input  logic                           cfg_write,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_BITS-1:0]           cfg_data,
    input  vpa_pkg::cmd_t                  cmd,
    output vpa_pkg::sts_t                  sts
);

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    logic [2*ADDR_BITS-1:0] seg_mem [MAX_SEGMENTS];

    addr_t                pool_base_reg, pool_length_reg;
    vpa_pkg::action_t     act_reg;
    addr_t                addr_reg, size_reg;
    cnt_t                 count_reg, count_next;
    cnt_t                 r_reg, r_next, w_reg, w_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    addr_t                pick_start_reg, pick_start_next;
    addr_t                pick_len_reg, pick_len_next;
    addr_t                cur_start_reg, cur_start_next;
    addr_t                cur_len_reg, cur_len_next;
    logic                 have_cur_reg, have_cur_next;
    logic                 inserted_reg, inserted_next;
    addr_t                rd_start_reg, rd_len_reg;
    vpa_pkg::status_t     st_reg, st_next;
    logic                 out_valid_reg;
    vpa_pkg::status_t     out_status_reg;
    addr_t                out_granted_reg;

    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_waddr;
    logic [2*ADDR_BITS-1:0] mem_wdata;

    logic                 cfg_hit;
    logic                 is_free, fits, better, at_pick, exact;
    logic                 e_valid, abut;
    addr_t                e_start, e_len, sat_len;
    logic [ADDR_BITS:0]   end_sum, len_sum;

    always_comb
    begin
        case (cfg_index)
            vpa_pkg::REG_POOL_BASE:   cfg_hit = cfg_write;
            vpa_pkg::REG_POOL_LENGTH: cfg_hit = cfg_write;
            default:                  cfg_hit = 1'b0;
        endcase
    end

    assign is_free = (act_reg == vpa_pkg::ACT_FREE);
    assign fits    = (rd_len_reg >= size_reg);
    assign better  = ((act_reg == vpa_pkg::ACT_BEST_FIT) && (rd_len_reg < pick_len_reg))
                  || ((act_reg == vpa_pkg::ACT_WORST_FIT) && (rd_len_reg > pick_len_reg));
    assign at_pick = !is_free && (r_reg == CNT_W'(pick_reg));
    assign exact   = (rd_len_reg == size_reg);

    assign sts.cfg_hit     = cfg_hit;
    assign sts.is_free     = is_free;
    assign sts.table_full  = (count_reg == CNT_W'(MAX_SEGMENTS));
    assign sts.table_empty = (count_reg == '0);
    assign sts.scan_done   = (fits && (act_reg == vpa_pkg::ACT_FIRST_FIT))
                          || ((r_reg + cnt_t'(1)) == count_reg);
    assign sts.found       = found_reg;
    assign sts.at_end      = (r_reg == count_reg);
    assign sts.ins_before  = is_free && !inserted_reg
                          && ((r_reg == '0) ? (addr_reg < rd_start_reg)
                                            : (rd_start_reg >= addr_reg));
    assign sts.out_busy    = out_valid_reg && !out_ready;

    // element handed to the merge stage this cycle
    always_comb
    begin
        e_valid = 1'b0;
        e_start = rd_start_reg;
        e_len   = rd_len_reg;
        if (cmd.pass_ev && sts.ins_before)
        begin
            e_valid = 1'b1;
            e_start = addr_reg;
            e_len   = size_reg;
        end
        else if (cmd.pass_ev && at_pick)
        begin
            e_valid = !exact;
            e_start = rd_start_reg + size_reg;
            e_len   = rd_len_reg - size_reg;
        end
        else if (cmd.pass_ev || cmd.pass_ev2)
        begin
            e_valid = 1'b1;
        end
        else if (cmd.pass_end && is_free && !inserted_reg)
        begin
            e_valid = 1'b1;
            e_start = addr_reg;
            e_len   = size_reg;
        end
    end

    assign end_sum = {1'b0, cur_start_reg} + {1'b0, cur_len_reg};
    assign len_sum = {1'b0, cur_len_reg} + {1'b0, e_len};
    assign sat_len = len_sum[ADDR_BITS] ? '1 : len_sum[ADDR_BITS-1:0];
    assign abut    = is_free && (end_sum == {1'b0, e_start});

    always_comb
    begin
        count_next      = count_reg;
        r_next          = r_reg;
        w_next          = w_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pick_start_next = pick_start_reg;
        pick_len_next   = pick_len_reg;
        cur_start_next  = cur_start_reg;
        cur_len_next    = cur_len_reg;
        have_cur_next   = have_cur_reg;
        inserted_next   = inserted_reg;
        st_next         = st_reg;
        mem_we          = 1'b0;
        mem_waddr       = w_reg[IDX_W-1:0];
        mem_wdata       = {cur_start_reg, cur_len_reg};
        mem_re          = cmd.scan_rd || cmd.pass_rd;

        if (cmd.init_write)
        begin
            mem_we     = 1'b1;
            mem_waddr  = '0;
            mem_wdata  = {pool_base_reg, pool_length_reg};
            count_next = cnt_t'(1);
        end
        if (cmd.load_item)
        begin
            r_next     = '0;
            found_next = 1'b0;
            st_next    = vpa_pkg::ST_OK;
        end
        if (cmd.set_full)
        begin
            st_next = vpa_pkg::ST_TABLE_FULL;
        end
        if (cmd.set_no_fit)
        begin
            st_next = vpa_pkg::ST_NO_FIT;
        end
        if (cmd.scan_ev)
        begin
            if (fits && (!found_reg || better))
            begin
                found_next      = 1'b1;
                pick_next       = r_reg[IDX_W-1:0];
                pick_start_next = rd_start_reg;
                pick_len_next   = rd_len_reg;
            end
            r_next = r_reg + cnt_t'(1);
        end
        if (cmd.pass_start)
        begin
            r_next        = is_free ? '0 : CNT_W'(pick_reg);
            w_next        = is_free ? '0 : CNT_W'(pick_reg);
            have_cur_next = 1'b0;
            inserted_next = 1'b0;
        end
        if (cmd.pass_ev)
        begin
            if (sts.ins_before)
            begin
                inserted_next = 1'b1;
            end
            else
            begin
                r_next = r_reg + cnt_t'(1);
            end
        end
        if (cmd.pass_ev2)
        begin
            r_next = r_reg + cnt_t'(1);
        end
        if (cmd.pass_end && is_free)
        begin
            inserted_next = 1'b1;
        end
        // merge stage: fold abutting element into the held one, else retire it
        if (e_valid)
        begin
            if (!have_cur_reg)
            begin
                have_cur_next  = 1'b1;
                cur_start_next = e_start;
                cur_len_next   = e_len;
            end
            else if (abut)
            begin
                cur_len_next = sat_len;
            end
            else
            begin
                mem_we         = 1'b1;
                w_next         = w_reg + cnt_t'(1);
                cur_start_next = e_start;
                cur_len_next   = e_len;
            end
        end
        if (cmd.flush)
        begin
            mem_we     = have_cur_reg;
            count_next = w_reg + cnt_t'(have_cur_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seg_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            {rd_start_reg, rd_len_reg} <= seg_mem[r_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg  <= vpa_pkg::action_t'(action);
            addr_reg <= address;
            size_reg <= request_size;
        end
        r_reg          <= r_next;
        w_reg          <= w_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        pick_start_reg <= pick_start_next;
        pick_len_reg   <= pick_len_next;
        cur_start_reg  <= cur_start_next;
        cur_len_reg    <= cur_len_next;
        have_cur_reg   <= have_cur_next;
        inserted_reg   <= inserted_next;
        st_reg         <= st_next;
        if (cmd.finish)
        begin
            out_status_reg  <= st_reg;
            out_granted_reg <= (!is_free && (st_reg == vpa_pkg::ST_OK)) ? pick_start_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg   <= '0;
            pool_length_reg <= '1;
            count_reg       <= cnt_t'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_hit && (cfg_index == vpa_pkg::REG_POOL_BASE))
            begin
                pool_base_reg <= cfg_data;
            end
            if (cfg_hit && (cfg_index == vpa_pkg::REG_POOL_LENGTH))
            begin
                pool_length_reg <= cfg_data;
            end
            count_reg <= count_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign granted_address = out_granted_reg;

endmodule

// ===== src/variable_partition_allocator.sv =====
// Accepting edge to out_valid: an alloc scans the held segments (first fit stops at a fit),
//   then rewrites from the pick on; a free rewrites every entry (S_PS_EV2 if it lands ahead);
//   a refused free (table full) or an alloc on an empty table is posted from dispatch. One item
//   at a time; input is ready again as the result is posted, once the last result is taken.
// Reset: asynchronous, active low; S_INIT then loads the pool segment into entry 0, and a
//   pool register write while idle reloads it the same way; one during an item does not.
module variable_partition_allocator
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int ADDR_BITS    = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // item input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     action,
    input  logic [ADDR_BITS-1:0]           address,
    input  logic [ADDR_BITS-1:0]           request_size,
    // result output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [ADDR_BITS-1:0]           granted_address,
    // pool configuration
    input  logic                           cfg_write,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_BITS-1:0]           cfg_data
);

    // Command and status bundles between the sequencer and the table datapath.
    vpa_pkg::cmd_t cmd;
    vpa_pkg::sts_t sts;

    // Sequencer: scan the table for a fit (allocations only), then stream it once through the
    // rewrite stage (insert, shrink, drop, merge) and post the result item.
    vpa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: segment memory, scan and pick registers, the merge holding
    // register and the output register that frees the input side early.
    vpa_dpath
    #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .action          (action),
        .address         (address),
        .request_size    (request_size),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .granted_address (granted_address),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule
